// ----- sv/slr_pkg.sv -----
// slr_pkg: widths, reset values, register indexes and shared types for the
// sta/lta ratio unit. no dependencies; every other file but slr_ring refers to it by scope.
package slr_pkg;

    localparam int LEN_W      = 11;           // window length registers
    localparam int PRE_W      = 46;           // long-window preload register
    localparam int SUM_W      = 64;           // running sums, wrap modulo 2^64
    localparam int RATIO_W    = 16;           // Q8.8 ratio
    localparam int FRAC_W     = 8;
    localparam int Q_W        = RATIO_W + 1;  // top quotient bit flags saturation
    localparam int PROD_W     = SUM_W + LEN_W;
    localparam int NUM_W      = PROD_W + FRAC_W;
    localparam int DIV_W      = PROD_W + Q_W - 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = PRE_W;

    localparam logic [LEN_W-1:0] MIN_WINDOW    = 11'd2;
    localparam logic [LEN_W-1:0] STA_RESET     = 11'd16;
    localparam logic [LEN_W-1:0] LTA_RESET     = 11'd256;
    localparam logic [PRE_W-1:0] PRELOAD_RESET = 46'h3FFF_FFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_STA_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LTA_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LTA_PRELOAD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_MODE = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_UPDATE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

    // status of a bit-serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_ser_status;

endpackage

// ----- sv/slr_ring.sv -----
// slr_ring: ring memory of past squares, one write port and two registered
// read ports. depends on nothing; contents are undefined until written.
module slr_ring #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 48
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_a <= mem[i_raddr_a];
            r_rd_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// ----- sv/slr_sermul.sv -----
// slr_sermul: bit-serial shift-add multiplier, one multiplier bit per cycle,
// msb first, product truncated to P_W bits. uses slr_pkg for its status type.
module slr_sermul #(
    parameter int A_W = 64,
    parameter int B_W = 11,
    parameter int P_W = 75
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic [P_W-1:0]       o_prod,
    output slr_pkg::t_ser_status o_status
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   r_a;
    logic [B_W-1:0]   r_b;
    logic [P_W-1:0]   r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= CNT_W'(B_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[P_W-2:0], 1'b0} + (r_b[B_W-1] ? P_W'(r_a) : '0);
            r_b   <= {r_b[B_W-2:0], 1'b0};
        end
    end

    assign o_prod          = r_acc;
    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;

endmodule

// ----- sv/slr_serdiv.sv -----
// slr_serdiv: restoring divider, one quotient bit per cycle, divisor held in a
// right-shifting register. uses slr_pkg for widths and the status type.
module slr_serdiv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [slr_pkg::NUM_W-1:0]   i_num,
    input  logic [slr_pkg::PROD_W-1:0]  i_den,
    output logic [slr_pkg::Q_W-1:0]     o_quot,
    output slr_pkg::t_ser_status        o_status
);

    localparam int DIV_W = slr_pkg::DIV_W;
    localparam int Q_W   = slr_pkg::Q_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [Q_W-1:0]   r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    assign w_diff = {1'b0, r_rem} - {1'b0, r_div};
    assign w_ge   = !w_diff[DIV_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= CNT_W'(Q_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DIV_W'(i_num);
            r_div <= {i_den, {(Q_W - 1){1'b0}}};
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_diff[DIV_W-1:0];
            end
            r_div <= {1'b0, r_div[DIV_W-1:1]};
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end
    end

    assign o_quot        = r_q;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

// ----- sv/sta_lta_ratio_unit.sv -----
// sta_lta_ratio_unit: sta/lta trigger ratio over squared samples, top level.
// depends on slr_pkg, slr_ring, slr_sermul and slr_serdiv.
//
//   channel   handshake                  payload
//   config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//   sample    i_valid / o_ready          i_sample, i_end_of_block
//   result    o_valid / i_ready          o_ratio, o_den_zero
//
// one item at a time: a new sample is taken only in idle, after the last item has
// gone through square and sums, the two serial window-length products, the
// bit-serial 17-bit quotient and the load of the output register.
// after reset, after a write to a length or the preload, and after an
// end-of-block item in record mode, the long-sum preload product runs
// serially; o_ready stays low until it is in place.
// a waiting result only stalls the unit when the next result is ready to load.
module sta_lta_ratio_unit #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [slr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [slr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample,
    input  logic                             i_end_of_block,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [slr_pkg::RATIO_W-1:0]      o_ratio,
    output logic                             o_den_zero
);

    localparam int LEN_W  = slr_pkg::LEN_W;
    localparam int SUM_W  = slr_pkg::SUM_W;
    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int FC_W   = $clog2(MAX_WINDOW + 1);
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int Q_W    = slr_pkg::Q_W;

    // configuration
    logic [LEN_W-1:0]          r_sta_length;
    logic [LEN_W-1:0]          r_lta_length;
    logic [slr_pkg::PRE_W-1:0] r_lta_preload;
    logic                      r_record_mode;

    // history
    logic [PTR_W-1:0]          r_wp;
    logic [FC_W-1:0]           r_fill;
    logic [SUM_W-1:0]          r_short;
    logic [SUM_W-1:0]          r_long;
    logic                      r_clr_pend;

    // item in flight
    slr_pkg::t_state           r_state;
    slr_pkg::t_state           n_state;
    logic [SAMPLE_BITS-1:0]    r_mag;
    logic                      r_eob;
    logic                      r_take_s;
    logic                      r_take_l;
    logic [SQ_W-1:0]           r_sq;
    logic [SUM_W-1:0]          r_st;
    logic [SUM_W-1:0]          r_lt;
    logic                      r_dz;

    // output register
    logic                      r_out_valid;
    logic [slr_pkg::RATIO_W-1:0] r_ratio;
    logic                      r_den_zero;

    logic                      w_cfg_acc;
    logic                      w_accept;
    logic [SAMPLE_BITS-1:0]    w_raw;
    logic [SAMPLE_BITS-1:0]    w_mag;
    logic [LEN_W-1:0]          w_eff_s;
    logic [LEN_W-1:0]          w_eff_l;
    logic [LEN_W-1:0]          w_off_s;
    logic [LEN_W-1:0]          w_off_l;
    logic [PTR_W-1:0]          w_poff_s;
    logic [PTR_W-1:0]          w_poff_l;
    logic [PTR_W-1:0]          w_addr_s;
    logic [PTR_W-1:0]          w_addr_l;
    logic [SQ_W-1:0]           w_rd_s;
    logic [SQ_W-1:0]           w_rd_l;
    logic [SUM_W-1:0]          w_leave_s;
    logic [SUM_W-1:0]          w_leave_l;
    logic                      w_mul_start;
    logic                      w_div_start;
    logic                      w_out_load;
    logic                      w_clr_busy;
    logic [SUM_W-1:0]          w_clr_prod;
    slr_pkg::t_ser_status      w_clr_status;
    logic [slr_pkg::PROD_W-1:0] w_num_prod;
    logic [slr_pkg::PROD_W-1:0] w_den_prod;
    slr_pkg::t_ser_status      w_num_status;
    slr_pkg::t_ser_status      w_den_status;
    logic [Q_W-1:0]            w_quot;
    slr_pkg::t_ser_status      w_div_status;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_clr_busy  = r_clr_pend || w_clr_status.busy || w_clr_status.done;
    assign o_ready     = (r_state == slr_pkg::ST_IDLE) && !w_clr_busy;
    assign w_accept    = i_valid && o_ready;

    assign w_raw = i_sample;
    assign w_mag = w_raw[SAMPLE_BITS-1] ? (~w_raw + SAMPLE_BITS'(1)) : w_raw;

    // effective window lengths, clamped into 2..MAX_WINDOW, long >= short
    always_comb begin
        w_eff_s = r_sta_length;
        if (r_sta_length < slr_pkg::MIN_WINDOW) begin
            w_eff_s = slr_pkg::MIN_WINDOW;
        end
        if (32'(r_sta_length) > MAX_WINDOW) begin
            w_eff_s = LEN_W'(MAX_WINDOW);
        end
        w_eff_l = r_lta_length;
        if (r_lta_length < slr_pkg::MIN_WINDOW) begin
            w_eff_l = slr_pkg::MIN_WINDOW;
        end
        if (32'(r_lta_length) > MAX_WINDOW) begin
            w_eff_l = LEN_W'(MAX_WINDOW);
        end
        if (w_eff_l < w_eff_s) begin
            w_eff_l = w_eff_s;
        end
    end

    assign w_off_s  = w_eff_s - LEN_W'(1);
    assign w_off_l  = w_eff_l - LEN_W'(1);
    assign w_poff_s = PTR_W'(w_off_s);
    assign w_poff_l = PTR_W'(w_off_l);

    // slot of the square leaving each window, wrapped around the ring
    assign w_addr_s = (r_wp >= w_poff_s) ? (r_wp - w_poff_s)
                    : PTR_W'({1'b0, r_wp} + (PTR_W + 1)'(MAX_WINDOW) - {1'b0, w_poff_s});
    assign w_addr_l = (r_wp >= w_poff_l) ? (r_wp - w_poff_l)
                    : PTR_W'({1'b0, r_wp} + (PTR_W + 1)'(MAX_WINDOW) - {1'b0, w_poff_l});

    assign w_leave_s = r_take_s ? SUM_W'(w_rd_s) : '0;
    assign w_leave_l = r_take_l ? SUM_W'(w_rd_l) : SUM_W'(r_lta_preload);

    slr_ring #(
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (PTR_W),
        .DATA_W (SQ_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_we      (r_state == slr_pkg::ST_SUM),
        .i_waddr   (r_wp),
        .i_wdata   (r_sq),
        .i_re      (w_accept),
        .i_raddr_a (w_addr_s),
        .i_raddr_b (w_addr_l),
        .o_rdata_a (w_rd_s),
        .o_rdata_b (w_rd_l)
    );

    // long sum after a history clear: (long length - 1) * preload
    slr_sermul #(
        .A_W (slr_pkg::PRE_W),
        .B_W (LEN_W),
        .P_W (SUM_W)
    ) u_clr_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_clr_pend),
        .i_a      (r_lta_preload),
        .i_b      (w_off_l),
        .o_prod   (w_clr_prod),
        .o_status (w_clr_status)
    );

    slr_sermul #(
        .A_W (SUM_W),
        .B_W (LEN_W),
        .P_W (slr_pkg::PROD_W)
    ) u_num_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_a      (r_st),
        .i_b      (w_eff_l),
        .o_prod   (w_num_prod),
        .o_status (w_num_status)
    );

    slr_sermul #(
        .A_W (SUM_W),
        .B_W (LEN_W),
        .P_W (slr_pkg::PROD_W)
    ) u_den_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_a      (r_lt),
        .i_b      (w_eff_s),
        .o_prod   (w_den_prod),
        .o_status (w_den_status)
    );

    slr_serdiv u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    ({w_num_prod, {slr_pkg::FRAC_W{1'b0}}}),
        .i_den    (w_den_prod),
        .o_quot   (w_quot),
        .o_status (w_div_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            slr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = slr_pkg::ST_SQUARE;
                end
            end
            slr_pkg::ST_SQUARE: begin
                n_state = slr_pkg::ST_SUM;
            end
            slr_pkg::ST_SUM: begin
                n_state = slr_pkg::ST_UPDATE;
            end
            slr_pkg::ST_UPDATE: begin
                w_mul_start = 1'b1;
                n_state     = slr_pkg::ST_MUL;
            end
            slr_pkg::ST_MUL: begin
                if (w_num_status.done && w_den_status.done) begin
                    w_div_start = 1'b1;
                    n_state     = slr_pkg::ST_DIV;
                end
            end
            slr_pkg::ST_DIV: begin
                if (w_div_status.done) begin
                    n_state = slr_pkg::ST_OUT;
                end
            end
            slr_pkg::ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    w_out_load = 1'b1;
                    n_state    = slr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slr_pkg::ST_IDLE;
            end
        endcase
    end

    // control state: configuration, history pointers and short sum, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sta_length  <= slr_pkg::STA_RESET;
            r_lta_length  <= slr_pkg::LTA_RESET;
            r_lta_preload <= slr_pkg::PRELOAD_RESET;
            r_record_mode <= 1'b0;
            r_wp          <= '0;
            r_fill        <= '0;
            r_short       <= '0;
            r_clr_pend    <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            // the pending flag starts the preload product this cycle
            r_clr_pend <= 1'b0;

            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    slr_pkg::CFG_STA_LENGTH: begin
                        r_sta_length <= i_cfg_data[LEN_W-1:0];
                        r_wp         <= '0;
                        r_fill       <= '0;
                        r_short      <= '0;
                        r_clr_pend   <= 1'b1;
                    end
                    slr_pkg::CFG_LTA_LENGTH: begin
                        r_lta_length <= i_cfg_data[LEN_W-1:0];
                        r_wp         <= '0;
                        r_fill       <= '0;
                        r_short      <= '0;
                        r_clr_pend   <= 1'b1;
                    end
                    slr_pkg::CFG_LTA_PRELOAD: begin
                        r_lta_preload <= i_cfg_data[slr_pkg::PRE_W-1:0];
                        r_wp          <= '0;
                        r_fill        <= '0;
                        r_short       <= '0;
                        r_clr_pend    <= 1'b1;
                    end
                    slr_pkg::CFG_RECORD_MODE: begin
                        r_record_mode <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end

            if (r_state == slr_pkg::ST_SUM) begin
                r_wp <= (r_wp == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_wp + PTR_W'(1);
                if (32'(r_fill) < MAX_WINDOW) begin
                    r_fill <= r_fill + FC_W'(1);
                end
            end

            if (r_state == slr_pkg::ST_UPDATE) begin
                if (r_record_mode && r_eob) begin
                    r_wp       <= '0;
                    r_fill     <= '0;
                    r_short    <= '0;
                    r_clr_pend <= 1'b1;
                end else begin
                    r_short <= r_st - w_leave_s;
                end
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mag    <= w_mag;
            r_eob    <= i_end_of_block;
            r_take_s <= 32'(r_fill) >= 32'(w_off_s);
            r_take_l <= 32'(r_fill) >= 32'(w_off_l);
        end
        if (r_state == slr_pkg::ST_SQUARE) begin
            r_sq <= SQ_W'(r_mag) * SQ_W'(r_mag);
        end
        if (r_state == slr_pkg::ST_SUM) begin
            r_st <= r_short + SUM_W'(r_sq);
            r_lt <= r_long + SUM_W'(r_sq);
        end
        if (r_state == slr_pkg::ST_UPDATE) begin
            r_dz <= (r_lt == '0);
            if (!(r_record_mode && r_eob)) begin
                r_long <= r_lt - w_leave_l;
            end
        end
        if (w_clr_status.done) begin
            r_long <= w_clr_prod;
        end
        if (w_out_load) begin
            r_den_zero <= r_dz;
            if (r_dz) begin
                r_ratio <= '0;
            end else if (w_quot[Q_W-1]) begin
                r_ratio <= '1;
            end else begin
                r_ratio <= w_quot[slr_pkg::RATIO_W-1:0];
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_ratio    = r_ratio;
    assign o_den_zero = r_den_zero;

endmodule
